### rtl/bgcd_pkg.sv
package bgcd_pkg;

    localparam int OPERAND_WIDTH = 64;
    localparam int SHIFT_WIDTH   = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [SHIFT_WIDTH-1:0]   shift_t;

    typedef struct packed {
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } bgcd_in_t;

    typedef struct packed {
        logic [63:0] divisor;
        logic        coprime;
    } bgcd_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bgcd_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMMON,
        ST_STRIP_A,
        ST_REDUCE,
        ST_RESTORE,
        ST_DONE
    } bgcd_state_t;

endpackage

### rtl/bgcd_core.sv
module bgcd_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  bgcd_pkg::bgcd_in_t    operands,
    input  logic                  take,
    output bgcd_pkg::bgcd_status_t status,
    output bgcd_pkg::operand_t    result
);
    import bgcd_pkg::*;

    bgcd_state_t state_reg;
    bgcd_state_t state_next;

    operand_t a_reg;
    operand_t a_next;
    operand_t b_reg;
    operand_t b_next;
    shift_t   k_reg;
    shift_t   k_next;

    operand_t                 a_in;
    operand_t                 b_in;
    logic                     zero_in;
    logic [OPERAND_WIDTH:0]   diff;
    logic                     borrow;
    logic                     diff_zero;

    assign a_in      = operands.operand_a[OPERAND_WIDTH-1:0];
    assign b_in      = operands.operand_b[OPERAND_WIDTH-1:0];
    assign zero_in   = (a_in == '0) || (b_in == '0);

    // the one shared subtractor: b - a with borrow out
    assign diff      = {1'b0, b_reg} - {1'b0, a_reg};
    assign borrow    = diff[OPERAND_WIDTH];
    assign diff_zero = (diff[OPERAND_WIDTH-1:0] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = zero_in ? ST_DONE : ST_COMMON;
                end
            end
            ST_COMMON:
            begin
                if (a_reg[0] || b_reg[0])
                begin
                    state_next = ST_STRIP_A;
                end
            end
            ST_STRIP_A:
            begin
                if (a_reg[0])
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (b_reg[0] && !borrow && diff_zero)
                begin
                    state_next = ST_RESTORE;
                end
            end
            ST_RESTORE:
            begin
                if (k_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // a zero operand leaves the other as the divisor
                    a_next = zero_in ? (a_in | b_in) : a_in;
                    b_next = b_in;
                    k_next = '0;
                end
            end
            ST_COMMON:
            begin
                if (!(a_reg[0] || b_reg[0]))
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + shift_t'(1);
                end
            end
            ST_STRIP_A:
            begin
                if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
            end
            ST_REDUCE:
            begin
                if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (borrow)
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
                else
                begin
                    b_next = diff[OPERAND_WIDTH-1:0];
                end
            end
            ST_RESTORE:
            begin
                if (k_reg != '0)
                begin
                    a_next = a_reg << 1;
                    k_next = k_reg - shift_t'(1);
                end
            end
            ST_DONE:
            begin
                a_next = a_reg;
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign result      = a_reg;

endmodule

### rtl/binary_gcd_coprime_test.sv
// Greatest common divisor of two unsigned 64-bit words by the binary (Stein)
// method, with a coprime flag that is set when the divisor is one. A zero
// operand gives the other operand as divisor, and two zeros give zero. One
// word is worked on at a time by a single subtractor and single-bit shifts
// under a small sequencer: after the accept it halves out each common
// factor of two, strips the trailing zeros from either operand, subtracts
// the smaller odd operand from the larger, swapping the two when the order
// is wrong, and shifts the common factors of two back in before it reaches
// the finished state. A zero operand goes straight from the accept to the
// finished state. The result sits in an output register, so the next word
// is taken once the previous result has moved there, even while it is
// still stalled.
module binary_gcd_coprime_test (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                operands_valid,
    output logic                operands_stall,
    input  bgcd_pkg::bgcd_in_t  operands,
    output logic                result_valid,
    input  logic                result_stall,
    output bgcd_pkg::bgcd_out_t result
);
    import bgcd_pkg::*;

    bgcd_status_t status;
    operand_t     core_result;
    logic         start;
    logic         take;
    logic         result_valid_reg;
    logic         result_valid_next;
    bgcd_out_t    result_reg;
    bgcd_out_t    result_next;

    assign operands_stall = status.busy;
    assign start          = operands_valid && !status.busy;
    assign take           = status.done && (!result_valid_reg || !result_stall);

    bgcd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operands (operands),
        .take     (take),
        .status   (status),
        .result   (core_result)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (take)
        begin
            result_valid_next   = 1'b1;
            result_next.divisor = 64'(core_result);
            result_next.coprime = (core_result == operand_t'(1));
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bgcd_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1200;

    typedef logic [63:0] word64_t;

    logic      clk            = 1'b0;
    logic      rst_n          = 1'b0;
    logic      operands_valid = 1'b0;
    logic      operands_stall;
    bgcd_in_t  operands       = '0;
    logic      result_valid;
    logic      result_stall   = 1'b0;
    bgcd_out_t result;

    bgcd_out_t pending_gcds[$];
    int        errors         = 0;
    int        cycles         = 0;
    bit        sender_idles   = 1'b1;
    bit        receiver_idles = 1'b1;
    bit        hold_request   = 1'b0;
    int        hold_left      = 0;
    int        stall_left     = 0;
    int        run_left       = 0;

    binary_gcd_coprime_test i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .operands_valid (operands_valid),
        .operands_stall (operands_stall),
        .operands       (operands),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("testbench failed");
            $finish;
        end
    end

    // greatest common divisor by halving and subtracting
    function automatic bgcd_out_t stein_divisor(bgcd_in_t w);
        operand_t  a;
        operand_t  b;
        operand_t  t;
        operand_t  g;
        int        twos;
        bgcd_out_t r;
        a    = w.operand_a;
        b    = w.operand_b;
        twos = 0;
        if (a == 0)
            g = b;
        else if (b == 0)
            g = a;
        else
        begin
            while (!a[0] && !b[0])
            begin
                a = a >> 1;
                b = b >> 1;
                twos++;
            end
            while (!a[0])
                a = a >> 1;
            do
            begin
                while (!b[0])
                    b = b >> 1;
                if (a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                b = b - a;
            end while (b != 0);
            g = a << twos;
        end
        r.divisor = 64'(g);
        r.coprime = (g == 1);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic word64_t rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic word64_t fib_word(int n);
        word64_t f0;
        word64_t f1;
        word64_t t;
        f0 = 0;
        f1 = 1;
        repeat (n)
        begin
            t  = f0 + f1;
            f0 = f1;
            f1 = t;
        end
        return f0;
    endfunction

    // result side: random stalls, plus a long hold when asked for
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else if (run_left > 0)
        begin
            result_stall <= 1'b0;
            run_left--;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left = receiver_idles ? pick_gap() : 0;
            run_left   = $urandom_range(0, 8);
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        bgcd_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_gcds.size() == 0)
            begin
                $display("%0t: unexpected result divisor %h coprime %b",
                         $time, result.divisor, result.coprime);
                errors++;
            end
            else
            begin
                want = pending_gcds.pop_front();
                if (result.divisor !== want.divisor)
                begin
                    $display("%0t: divisor expected %h actual %h",
                             $time, want.divisor, result.divisor);
                    errors++;
                end
                if (result.coprime !== want.coprime)
                begin
                    $display("%0t: coprime expected %b actual %b",
                             $time, want.coprime, result.coprime);
                    errors++;
                end
            end
        end
    end

    task automatic send_operands(word64_t a, word64_t b);
        bgcd_in_t w;
        int       gap;
        w.operand_a = a;
        w.operand_b = b;
        operands_valid <= 1'b1;
        operands       <= w;
        do
            @(posedge clk);
        while (operands_stall);
        pending_gcds.push_back(stein_divisor(w));
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            operands_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic test_directed();
        word64_t ones;
        ones = '1;
        send_operands(0, 0);
        send_operands(0, 5);
        send_operands(7, 0);
        send_operands(0, 1);
        send_operands(1, 0);
        send_operands(0, ones);
        send_operands(ones, 0);
        send_operands(1, 1);
        send_operands(ones, ones);
        send_operands(ones, 1);
        send_operands(1, ones);
        send_operands(ones, ones - 1);
        send_operands(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_operands(64'h8000_0000_0000_0000, 1);
        send_operands(4, 6);
        send_operands(12, 18);
        send_operands(48, 180);
        send_operands(6, 35);
        send_operands(fib_word(93), fib_word(92));
        send_operands(fib_word(92), fib_word(93));
        send_operands(ones - 1, ones - 3);
        send_operands(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    endtask

    task automatic send_random_pair();
        word64_t a;
        word64_t b;
        word64_t g;
        int      k;
        case ($urandom_range(0, 9))
            0:
            begin
                a = rand_word();
                b = rand_word();
            end
            1:
            begin
                g = $urandom_range(1, 65535);
                a = g * $urandom_range(1, 1 << 24);
                b = g * $urandom_range(1, 1 << 24);
            end
            2:
            begin
                k = $urandom_range(0, 40);
                a = word64_t'($urandom) << k;
                b = word64_t'($urandom) << k;
            end
            3:
            begin
                a = $urandom_range(0, 20);
                b = $urandom_range(0, 20);
            end
            4:
            begin
                a = $urandom_range(0, 1);
                b = rand_word() >> $urandom_range(0, 63);
                if ($urandom_range(0, 1))
                begin
                    g = a;
                    a = b;
                    b = g;
                end
            end
            5:
            begin
                a = ~word64_t'($urandom_range(0, 255));
                b = rand_word();
            end
            6:
            begin
                a = rand_word() >> $urandom_range(0, 63);
                b = a;
            end
            7:
            begin
                k = $urandom_range(1, 92);
                a = fib_word(k + 1);
                b = fib_word(k);
            end
            default:
            begin
                a = rand_word() >> $urandom_range(0, 63);
                b = rand_word() >> $urandom_range(0, 63);
            end
        endcase
        send_operands(a, b);
    endtask

    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
            begin
                sender_idles   = ($urandom_range(0, 3) != 0);
                receiver_idles = ($urandom_range(0, 3) != 0);
            end
            send_random_pair();
        end
        operands_valid <= 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_backpressure();
        sender_idles = 1'b0;
        hold_request = 1'b1;
        repeat (30) send_random_pair();
        sender_idles = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        while (pending_gcds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
